/* rtl/rmlm_pkg.sv */
package rmlm_pkg;

   // Field widths and fixed-point formats
   localparam int DATA_W    = 32;                 // matrix entry and axis width, Q1.30
   localparam int FRAC_BITS = 30;
   localparam int CFG_W     = 31;                 // tolerance register width
   localparam int ANG_W     = 31;                 // angle width, unsigned Q2.29
   localparam int ANG_FRAC  = FRAC_BITS - 1;
   localparam int CODE_W    = 3;
   localparam int CSR_IDX_W = 1;

   // Datapath sizing
   localparam int WIDE_W       = 64;              // radicands, dividends, angle accumulator
   localparam int ISQRT_IN_W   = WIDE_W;
   localparam int ISQRT_STAGES = ISQRT_IN_W / 2;
   localparam int ROOT_W       = ISQRT_IN_W / 2;
   localparam int QUOT_W       = DATA_W - 1;
   localparam int DIV_STAGES   = QUOT_W + 1;      // saturation check plus one bit per stage
   localparam int CORDIC_STEPS = 40;
   localparam int CORDIC_PRE   = 20;              // input scale shift
   localparam int CD_W         = 56;              // CORDIC x/y width
   localparam int Z_FRAC       = 60;              // angle accumulator fraction bits

   typedef enum logic [CODE_W-1:0] {
      CODE_NORMAL  = 3'd0,
      CODE_IDENT   = 3'd1,
      CODE_PI_COL2 = 3'd2,
      CODE_PI_COL1 = 3'd3,
      CODE_PI_COL0 = 3'd4,
      CODE_ERROR   = 3'd5
   } case_code_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IDENT_TOL = 1'd0,
      CSR_PI_TOL    = 1'd1
   } csr_index_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] entry_r0c0;
      logic signed [DATA_W-1:0] entry_r0c1;
      logic signed [DATA_W-1:0] entry_r0c2;
      logic signed [DATA_W-1:0] entry_r1c0;
      logic signed [DATA_W-1:0] entry_r1c1;
      logic signed [DATA_W-1:0] entry_r1c2;
      logic signed [DATA_W-1:0] entry_r2c0;
      logic signed [DATA_W-1:0] entry_r2c1;
      logic signed [DATA_W-1:0] entry_r2c2;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] axis_x;
      logic signed [DATA_W-1:0] axis_y;
      logic signed [DATA_W-1:0] axis_z;
      logic [ANG_W-1:0]         angle;
      logic [CODE_W-1:0]        case_code;
   } rsp_type;

   // Divide by the odd number 2k+1 for k up to 29; all divisors are literals
   function automatic logic [WIDE_W-1:0] div_odd(input logic [WIDE_W-1:0] p, input int k);
      logic [WIDE_W-1:0] q;
      case (k)
         0:  q = p / 1;
         1:  q = p / 3;
         2:  q = p / 5;
         3:  q = p / 7;
         4:  q = p / 9;
         5:  q = p / 11;
         6:  q = p / 13;
         7:  q = p / 15;
         8:  q = p / 17;
         9:  q = p / 19;
         10: q = p / 21;
         11: q = p / 23;
         12: q = p / 25;
         13: q = p / 27;
         14: q = p / 29;
         15: q = p / 31;
         16: q = p / 33;
         17: q = p / 35;
         18: q = p / 37;
         19: q = p / 39;
         20: q = p / 41;
         21: q = p / 43;
         22: q = p / 45;
         23: q = p / 47;
         24: q = p / 49;
         25: q = p / 51;
         26: q = p / 53;
         27: q = p / 55;
         28: q = p / 57;
         29: q = p / 59;
         default: q = p;
      endcase
      return q;
   endfunction

   // pi/4 in Q60 by Machin: 4*atan(1/5) - atan(1/239), truncated series
   function automatic logic signed [WIDE_W-1:0] quarter_pi_q60();
      logic [WIDE_W-1:0]        p5;
      logic [WIDE_W-1:0]        p239;
      logic signed [WIDE_W-1:0] s5;
      logic signed [WIDE_W-1:0] s239;
      logic signed [WIDE_W-1:0] t;
      p5   = (64'd1 << 60) / 5;
      p239 = (64'd1 << 60) / 239;
      s5   = '0;
      s239 = '0;
      for (int k = 0; k < 30; k++) begin
         if (p5 != '0) begin
            t  = $signed(div_odd(p5, k));
            s5 = (k % 2 == 1) ? s5 - t : s5 + t;
            p5 = p5 / 25;
         end
         if (p239 != '0) begin
            t    = $signed(div_odd(p239, k));
            s239 = (k % 2 == 1) ? s239 - t : s239 + t;
            p239 = p239 / 57121;
         end
      end
      return 4 * s5 - s239;
   endfunction

   localparam logic signed [WIDE_W-1:0] QUARTER_PI = quarter_pi_q60();
   localparam logic [WIDE_W-1:0] ANG_HALF = 64'd1 << (Z_FRAC - ANG_FRAC - 1);
   localparam logic [WIDE_W-1:0] PI_OUT_W =
      (64'(4 * QUARTER_PI) + ANG_HALF) >> (Z_FRAC - ANG_FRAC);
   localparam logic [ANG_W-1:0] PI_OUT = PI_OUT_W[ANG_W-1:0];

   // atan(2^-i) in Q60
   function automatic logic signed [WIDE_W-1:0] atan_pow2_q60(input int i);
      logic signed [WIDE_W-1:0] sum;
      logic signed [WIDE_W-1:0] t;
      logic [WIDE_W-1:0]        p;
      sum = '0;
      if (i == 0) begin
         sum = QUARTER_PI;
      end else begin
         for (int k = 0; k < 30; k++) begin
            if (i * (2 * k + 1) <= Z_FRAC) begin
               p   = 64'd1 << (Z_FRAC - i * (2 * k + 1));
               t   = $signed(div_odd(p, k));
               sum = (k % 2 == 1) ? sum - t : sum + t;
            end
         end
      end
      return sum;
   endfunction

   // Arithmetic shift right rounding toward zero
   function automatic logic signed [CD_W-1:0] shr_tz(input logic signed [CD_W-1:0] v,
                                                     input int s);
      logic signed [CD_W-1:0] r;
      if (v < 0) begin
         r = -((-v) >>> s);
      end else begin
         r = v >>> s;
      end
      return r;
   endfunction

endpackage

/* rtl/rmlm_isqrt_pipe.sv */
module rmlm_isqrt_pipe #(
   parameter int IN_W = rmlm_pkg::ISQRT_IN_W
) (
   input  logic              clock,
   input  logic              enable,
   input  logic [IN_W-1:0]   radicand,
   output logic [IN_W/2-1:0] root
);
   import rmlm_pkg::*;

   localparam int NS = IN_W / 2;

   // one result bit per stage; last stage keeps only the root
   logic [IN_W-1:0] rem_ff [NS-1];
   logic [IN_W-1:0] rem_in [NS-1];
   logic [IN_W-1:0] res_ff [NS];
   logic [IN_W-1:0] res_in [NS];

   for (genvar j = 0; j < NS; j++) begin : g_stage
      localparam logic [IN_W-1:0] BIT_W = IN_W'(1) << (IN_W - 2 - 2 * j);
      logic [IN_W-1:0] rem_src;
      logic [IN_W-1:0] res_src;
      logic [IN_W-1:0] trial;
      logic            take;

      if (j == 0) begin : g_first
         assign rem_src = radicand;
         assign res_src = '0;
      end else begin : g_next
         assign rem_src = rem_ff[j-1];
         assign res_src = res_ff[j-1];
      end

      assign trial = res_src + BIT_W;
      assign take  = (rem_src >= trial);

      always_comb begin
         res_in[j] = take ? ((res_src >> 1) + BIT_W) : (res_src >> 1);
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            res_ff[j] <= res_in[j];
         end
      end

      if (j < NS - 1) begin : g_rem
         always_comb begin
            rem_in[j] = take ? (rem_src - trial) : rem_src;
         end
         always_ff @(posedge clock) begin
            if (enable) begin
               rem_ff[j] <= rem_in[j];
            end
         end
      end
   end

   assign root = res_ff[NS-1][NS-1:0];

endmodule

/* rtl/rmlm_div_pipe.sv */
module rmlm_div_pipe #(
   parameter int DIVIDEND_W = rmlm_pkg::WIDE_W,
   parameter int DIVISOR_W  = rmlm_pkg::ROOT_W,
   parameter int QW         = rmlm_pkg::QUOT_W
) (
   input  logic                  clock,
   input  logic                  enable,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic [QW-1:0]         quotient,
   output logic                  saturated
);
   import rmlm_pkg::*;

   // stage 0: overflow check; stages 1..QW: one quotient bit each, MSB first
   logic [DIVIDEND_W-1:0] rem_ff [QW];
   logic [DIVIDEND_W-1:0] rem_in [QW];
   logic [DIVISOR_W-1:0]  den_ff [QW];
   logic [QW-1:0]         q_ff   [1:QW];
   logic [QW-1:0]         q_in   [1:QW];
   logic                  sat_ff [QW+1];
   logic                  sat_in;

   assign sat_in = (dividend >= (DIVIDEND_W'(divisor) << QW));

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff[0] <= dividend;
         den_ff[0] <= divisor;
         sat_ff[0] <= sat_in;
      end
   end

   for (genvar j = 1; j <= QW; j++) begin : g_stage
      localparam int B = QW - j;
      logic [DIVIDEND_W-1:0] trial;
      logic [QW-1:0]         q_src;
      logic                  take;

      if (j == 1) begin : g_first
         assign q_src = '0;
      end else begin : g_next
         assign q_src = q_ff[j-1];
      end

      assign trial = DIVIDEND_W'(den_ff[j-1]) << B;
      assign take  = (rem_ff[j-1] >= trial);

      always_comb begin
         q_in[j] = q_src | (QW'(take) << B);
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            q_ff[j]   <= q_in[j];
            sat_ff[j] <= sat_ff[j-1];
         end
      end

      if (j < QW) begin : g_rem
         always_comb begin
            rem_in[j] = take ? (rem_ff[j-1] - trial) : rem_ff[j-1];
         end
         always_ff @(posedge clock) begin
            if (enable) begin
               rem_ff[j] <= rem_in[j];
               den_ff[j] <= den_ff[j-1];
            end
         end
      end
   end

   assign quotient  = q_ff[QW];
   assign saturated = sat_ff[QW];

endmodule

/* rtl/rotation_matrix_log_map_core.sv */
// Pipeline from an accepted request transaction to its response
//   (2 setup stages, 1 squaring stage, 32 square-root stages, 40 CORDIC stages, 1 output).
// Throughput: one matrix per cycle while no response stalls; every stage is a register level.
// A stalled response freezes the whole pipeline; req_stall follows it directly.
// Reset (synchronous, active high) clears all valid bits and sets both tolerances to 1.
module rotation_matrix_log_map_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  rmlm_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output rmlm_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_wr_en,
   input  logic [rmlm_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [rmlm_pkg::CFG_W-1:0]           csr_wdata
);
   import rmlm_pkg::*;

   // Pipeline positions: P0 input, P1 setup, P2 square, P34 roots, P74 angle, P75 output
   localparam int LAT     = 3 + ISQRT_STAGES + CORDIC_STEPS;
   localparam int DIV_PAD = CORDIC_STEPS - DIV_STAGES;
   localparam int EW      = DATA_W + 3;   // headroom for sums of three entries
   localparam logic signed [EW-1:0] ONE     = EW'(1) << FRAC_BITS;
   localparam logic signed [DATA_W:0] C2_MAX = (DATA_W+1)'(1) << (FRAC_BITS + 1);
   localparam logic [WIDE_W-1:0]    FOUR_SQ = WIDE_W'(1) << (2 * FRAC_BITS + 2);
   localparam logic [QUOT_W-1:0]    Q_MAX   = '1;

   // sideband carried alongside the square roots
   typedef struct packed {
      logic                     ident;
      logic                     near_pi;
      logic                     col_ok;
      case_code_type            code_pi;
      logic signed [DATA_W:0]   c2;
      logic [2:0]               nsign;
      logic [2:0][WIDE_W-1:0]   nmag;
   } side_a_type;

   // sideband carried alongside the CORDIC
   typedef struct packed {
      case_code_type            code;
      logic [2:0]               nsign;
   } side_b_type;

   typedef struct packed {
      logic [QUOT_W-1:0]        q;
      logic                     sat;
   } quot_type;

   //--------------------------------------------------------------------------
   // Configuration registers
   //--------------------------------------------------------------------------
   logic [CFG_W-1:0] ident_tol_ff;
   logic [CFG_W-1:0] pi_tol_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ident_tol_ff <= CFG_W'(1);
         pi_tol_ff    <= CFG_W'(1);
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_IDENT_TOL: ident_tol_ff <= csr_wdata;
            CSR_PI_TOL:    pi_tol_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   //--------------------------------------------------------------------------
   // Flow control: one global advance; valid bits shift with the data
   //--------------------------------------------------------------------------
   logic           adv;
   logic [LAT:0]   vld_ff;
   logic [LAT:0]   vld_in;

   assign adv       = !(vld_ff[LAT] && rsp_stall);
   assign req_stall = !adv;
   assign rsp_valid = vld_ff[LAT];
   assign vld_in    = {vld_ff[LAT-1:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   //--------------------------------------------------------------------------
   // P0: capture the matrix
   //--------------------------------------------------------------------------
   req_type in_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         in_ff <= req_data;
      end
   end

   //--------------------------------------------------------------------------
   // P1: identity test, trace, near-pi column pick, axis numerators
   //--------------------------------------------------------------------------
   logic signed [EW-1:0] d0;
   logic signed [EW-1:0] d1;
   logic signed [EW-1:0] d2;
   logic signed [EW-1:0] itol;
   logic signed [EW-1:0] ptol;
   logic signed [EW-1:0] trace;
   logic signed [EW-1:0] cos2;
   logic signed [EW-1:0] dcol;
   logic signed [EW-1:0] num [3];
   logic signed [EW-1:0] mag [3];
   logic                 use_col;
   side_a_type           sa1_in;
   side_a_type           sa1_ff;
   logic [WIDE_W-1:0]    vq1_in;
   logic [WIDE_W-1:0]    vq1_ff;

   always_comb begin
      d0   = EW'(in_ff.entry_r0c0);
      d1   = EW'(in_ff.entry_r1c1);
      d2   = EW'(in_ff.entry_r2c2);
      itol = $signed(EW'(ident_tol_ff));
      ptol = $signed(EW'(pi_tol_ff));

      sa1_in.ident = (d0 - ONE <= itol) && (ONE - d0 <= itol) &&
                     (d1 - ONE <= itol) && (ONE - d1 <= itol) &&
                     (d2 - ONE <= itol) && (ONE - d2 <= itol);

      trace = d0 + d1 + d2;
      cos2  = trace - ONE;
      if (cos2 > EW'(C2_MAX)) begin
         cos2 = EW'(C2_MAX);
      end else if (cos2 < -EW'(C2_MAX)) begin
         cos2 = -EW'(C2_MAX);
      end
      sa1_in.c2      = cos2[DATA_W:0];
      sa1_in.near_pi = (trace + ONE < ptol);

      // first usable column in the order 2, 1, 0
      sa1_in.col_ok = 1'b1;
      if (d2 + ONE > ptol) begin
         sa1_in.code_pi = CODE_PI_COL2;
         dcol           = d2 + ONE;
      end else if (d1 + ONE > ptol) begin
         sa1_in.code_pi = CODE_PI_COL1;
         dcol           = d1 + ONE;
      end else if (d0 + ONE > ptol) begin
         sa1_in.code_pi = CODE_PI_COL0;
         dcol           = d0 + ONE;
      end else begin
         sa1_in.code_pi = CODE_ERROR;
         sa1_in.col_ok  = 1'b0;
         dcol           = ONE;
      end
      use_col = sa1_in.near_pi && sa1_in.col_ok;

      // 2*d scaled by 2^30 for the near-pi normalizer
      vq1_in = WIDE_W'(dcol[DATA_W-1:0]) << (FRAC_BITS + 1);

      if (use_col) begin
         case (sa1_in.code_pi)
            CODE_PI_COL2: begin
               num[0] = EW'(in_ff.entry_r0c2);
               num[1] = EW'(in_ff.entry_r1c2);
               num[2] = dcol;
            end
            CODE_PI_COL1: begin
               num[0] = EW'(in_ff.entry_r0c1);
               num[1] = dcol;
               num[2] = EW'(in_ff.entry_r2c1);
            end
            default: begin
               num[0] = dcol;
               num[1] = EW'(in_ff.entry_r1c0);
               num[2] = EW'(in_ff.entry_r2c0);
            end
         endcase
      end else begin
         // skew part
         num[0] = EW'(in_ff.entry_r2c1) - EW'(in_ff.entry_r1c2);
         num[1] = EW'(in_ff.entry_r0c2) - EW'(in_ff.entry_r2c0);
         num[2] = EW'(in_ff.entry_r1c0) - EW'(in_ff.entry_r0c1);
      end

      for (int k = 0; k < 3; k++) begin
         mag[k]          = (num[k] < 0) ? -num[k] : num[k];
         sa1_in.nsign[k] = (num[k] < 0);
         sa1_in.nmag[k]  = use_col ? (WIDE_W'(mag[k][DATA_W:0]) << FRAC_BITS)
                                   : (WIDE_W'(mag[k][DATA_W:0]) << (FRAC_BITS + 1));
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sa1_ff <= sa1_in;
         vq1_ff <= vq1_in;
      end
   end

   //--------------------------------------------------------------------------
   // P2: square the cosine term
   //--------------------------------------------------------------------------
   side_a_type                  sa2_ff;
   logic [WIDE_W-1:0]           vq2_ff;
   logic signed [2*DATA_W+1:0]  sq_in;
   logic [WIDE_W-1:0]           sq_ff;
   logic [WIDE_W-1:0]           vs2;

   assign sq_in = sa1_ff.c2 * sa1_ff.c2;

   always_ff @(posedge clock) begin
      if (adv) begin
         sa2_ff <= sa1_ff;
         vq2_ff <= vq1_ff;
         sq_ff  <= sq_in[WIDE_W-1:0];
      end
   end

   assign vs2 = FOUR_SQ - sq_ff;

   //--------------------------------------------------------------------------
   // P2..P34: square roots (sine term and near-pi normalizer)
   //--------------------------------------------------------------------------
   logic [ROOT_W-1:0] sin2;
   logic [ROOT_W-1:0] qnorm;
   side_a_type        sa_dly_ff [ISQRT_STAGES];

   rmlm_isqrt_pipe #(.IN_W(ISQRT_IN_W)) u_sqrt_sin (
      .clock    (clock),
      .enable   (adv),
      .radicand (vs2),
      .root     (sin2)
   );

   rmlm_isqrt_pipe #(.IN_W(ISQRT_IN_W)) u_sqrt_norm (
      .clock    (clock),
      .enable   (adv),
      .radicand (vq2_ff),
      .root     (qnorm)
   );

   always_ff @(posedge clock) begin
      if (adv) begin
         sa_dly_ff[0] <= sa2_ff;
         for (int k = 1; k < ISQRT_STAGES; k++) begin
            sa_dly_ff[k] <= sa_dly_ff[k-1];
         end
      end
   end

   //--------------------------------------------------------------------------
   // P34: case decision, divisor pick, CORDIC pre-rotation
   //--------------------------------------------------------------------------
   side_a_type        sa34;
   side_b_type        sb34;
   logic [ROOT_W-1:0] den34;

   assign sa34 = sa_dly_ff[ISQRT_STAGES-1];

   always_comb begin
      sb34.nsign = sa34.nsign;
      if (sa34.ident) begin
         sb34.code = CODE_IDENT;
      end else if (sa34.near_pi) begin
         sb34.code = sa34.col_ok ? sa34.code_pi : CODE_ERROR;
      end else if (sin2 == '0) begin
         sb34.code = CODE_ERROR;
      end else begin
         sb34.code = CODE_NORMAL;
      end
      den34 = sa34.near_pi ? qnorm : sin2;
   end

   //--------------------------------------------------------------------------
   // P34..P66: axis divisions, then padded to line up with the CORDIC
   //--------------------------------------------------------------------------
   quot_type quot [3];
   quot_type qd_ff [DIV_PAD][3];

   for (genvar k = 0; k < 3; k++) begin : g_div
      rmlm_div_pipe #(
         .DIVIDEND_W (WIDE_W),
         .DIVISOR_W  (ROOT_W),
         .QW         (QUOT_W)
      ) u_div (
         .clock     (clock),
         .enable    (adv),
         .dividend  (sa34.nmag[k]),
         .divisor   (den34),
         .quotient  (quot[k].q),
         .saturated (quot[k].sat)
      );
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         qd_ff[0] <= quot;
         for (int k = 1; k < DIV_PAD; k++) begin
            qd_ff[k] <= qd_ff[k-1];
         end
      end
   end

   //--------------------------------------------------------------------------
   // P34..P74: CORDIC vectoring, one micro-rotation per stage
   //--------------------------------------------------------------------------
   logic signed [CD_W-1:0]   x0;
   logic signed [CD_W-1:0]   y0;
   logic signed [CD_W-1:0]   xp;
   logic signed [CD_W-1:0]   yp;
   logic signed [WIDE_W-1:0] zp;
   logic signed [CD_W-1:0]   cx_ff [CORDIC_STEPS-1];
   logic signed [CD_W-1:0]   cx_in [CORDIC_STEPS-1];
   logic signed [CD_W-1:0]   cy_ff [CORDIC_STEPS-1];
   logic signed [CD_W-1:0]   cy_in [CORDIC_STEPS-1];
   logic signed [WIDE_W-1:0] cz_ff [CORDIC_STEPS];
   logic signed [WIDE_W-1:0] cz_in [CORDIC_STEPS];
   side_b_type               sb_dly_ff [CORDIC_STEPS];

   always_comb begin
      x0 = CD_W'(sa34.c2) <<< CORDIC_PRE;
      y0 = $signed(CD_W'(sin2)) <<< CORDIC_PRE;
      // quarter-turn pre-rotation for obtuse angles
      if (x0 < 0) begin
         xp = y0;
         yp = -x0;
         zp = 2 * QUARTER_PI;
      end else begin
         xp = x0;
         yp = y0;
         zp = '0;
      end
   end

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
      localparam logic signed [WIDE_W-1:0] ATAN_I = atan_pow2_q60(i);
      logic signed [CD_W-1:0]   xs;
      logic signed [CD_W-1:0]   ys;
      logic signed [WIDE_W-1:0] zs;
      logic signed [CD_W-1:0]   dx;
      logic signed [CD_W-1:0]   dy;
      logic                     up;

      if (i == 0) begin : g_first
         assign xs = xp;
         assign ys = yp;
         assign zs = zp;
      end else begin : g_next
         assign xs = cx_ff[i-1];
         assign ys = cy_ff[i-1];
         assign zs = cz_ff[i-1];
      end

      assign dx = shr_tz(xs, i);
      assign dy = shr_tz(ys, i);
      assign up = (ys > 0);

      always_comb begin
         cz_in[i] = up ? (zs + ATAN_I) : (zs - ATAN_I);
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            cz_ff[i] <= cz_in[i];
         end
      end

      if (i < CORDIC_STEPS - 1) begin : g_xy
         always_comb begin
            cx_in[i] = up ? (xs + dy) : (xs - dy);
            cy_in[i] = up ? (ys - dx) : (ys + dx);
         end
         always_ff @(posedge clock) begin
            if (adv) begin
               cx_ff[i] <= cx_in[i];
               cy_ff[i] <= cy_in[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sb_dly_ff[0] <= sb34;
         for (int k = 1; k < CORDIC_STEPS; k++) begin
            sb_dly_ff[k] <= sb_dly_ff[k-1];
         end
      end
   end

   //--------------------------------------------------------------------------
   // P74 -> P75: round the angle, saturate and sign the axis
   //--------------------------------------------------------------------------
   side_b_type               sb74;
   quot_type                 q74 [3];
   logic signed [WIDE_W-1:0] z74;
   logic [WIDE_W-1:0]        zr;
   logic [QUOT_W-1:0]        qs;
   logic                     zero_axis;
   logic signed [DATA_W-1:0] ax [3];
   rsp_type                  rsp_in;
   rsp_type                  rsp_ff;

   assign sb74 = sb_dly_ff[CORDIC_STEPS-1];
   assign q74  = qd_ff[DIV_PAD-1];
   assign z74  = cz_ff[CORDIC_STEPS-1];

   always_comb begin
      zero_axis = (sb74.code == CODE_IDENT) || (sb74.code == CODE_ERROR);
      for (int k = 0; k < 3; k++) begin
         qs = q74[k].sat ? Q_MAX : q74[k].q;
         if (zero_axis) begin
            ax[k] = '0;
         end else if (sb74.nsign[k]) begin
            ax[k] = -$signed({1'b0, qs});
         end else begin
            ax[k] = $signed({1'b0, qs});
         end
      end

      // Q60 to unsigned Q2.29, round half up, clamp to pi
      zr = ($unsigned(z74) + ANG_HALF) >> (Z_FRAC - ANG_FRAC);
      if ((sb74.code == CODE_IDENT) || (z74 <= 0)) begin
         rsp_in.angle = '0;
      end else if (zr > PI_OUT_W) begin
         rsp_in.angle = PI_OUT;
      end else begin
         rsp_in.angle = zr[ANG_W-1:0];
      end

      rsp_in.axis_x    = ax[0];
      rsp_in.axis_y    = ax[1];
      rsp_in.axis_z    = ax[2];
      rsp_in.case_code = sb74.code;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

   //--------------------------------------------------------------------------
   // Assertions
   //--------------------------------------------------------------------------
   a_ident_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.case_code == CODE_IDENT) |->
         (rsp_data.axis_x == '0) && (rsp_data.axis_y == '0) &&
         (rsp_data.axis_z == '0) && (rsp_data.angle == '0))
      else $error("identity transaction with nonzero axis or angle");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.case_code == CODE_ERROR) |->
         (rsp_data.axis_x == '0) && (rsp_data.axis_y == '0) && (rsp_data.axis_z == '0))
      else $error("error transaction with nonzero axis");

   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.angle <= PI_OUT))
      else $error("angle above pi");

   a_code_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.case_code == CODE_NORMAL) ||
                    (rsp_data.case_code == CODE_IDENT) ||
                    (rsp_data.case_code == CODE_PI_COL2) ||
                    (rsp_data.case_code == CODE_PI_COL1) ||
                    (rsp_data.case_code == CODE_PI_COL0) ||
                    (rsp_data.case_code == CODE_ERROR))
      else $error("undefined case code");

endmodule

/* tb/rmlm_checker.sv */
module rmlm_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  rmlm_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  rmlm_pkg::rsp_type rsp_data,
   input  logic              csr_wr_en,
   input  logic [rmlm_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [rmlm_pkg::CFG_W-1:0]     csr_wdata,
   output int                fail_count,
   output int                pending
);
   import rmlm_pkg::*;

   localparam longint ONE = 64'sd1 << FRAC_BITS;

   longint          ident_tol;
   longint          pi_tol;
   longint          atan_q60 [CORDIC_STEPS];
   longint          quarter_pi;
   rsp_type         expected_poses [$];

   function automatic longint atan_recip(longint unsigned m);
      longint unsigned p;
      longint unsigned k;
      longint          sum;
      p   = (64'd1 << 60) / m;
      k   = 0;
      sum = 0;
      while (p != 0) begin
         sum = (k[0]) ? sum - longint'(p / (2 * k + 1)) : sum + longint'(p / (2 * k + 1));
         p   = p / (m * m);
         k++;
      end
      return sum;
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic longint trunc_shift(longint v, int s);
      return (v >= 0) ? (v >>> s) : -((-v) >>> s);
   endfunction

   // atan2 by vectoring CORDIC, Q60 accumulator rounded to unsigned Q2.29
   function automatic logic [ANG_W-1:0] rot_angle(longint c2, longint s2);
      longint          x;
      longint          y;
      longint          z;
      longint          dx;
      longint          dy;
      longint          t;
      longint unsigned half;
      longint unsigned pi_q;
      longint unsigned r;
      x    = c2 * (64'sd1 << 20);
      y    = s2 * (64'sd1 << 20);
      z    = 0;
      half = 64'd1 << 30;
      pi_q = (longint'(4 * quarter_pi) + half) >> 31;
      if (x < 0) begin
         t = x;
         x = y;
         y = -t;
         z = 2 * quarter_pi;
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         dx = trunc_shift(x, i);
         dy = trunc_shift(y, i);
         if (y > 0) begin
            x = x + dy; y = y - dx; z = z + atan_q60[i];
         end else begin
            x = x - dy; y = y + dx; z = z - atan_q60[i];
         end
      end
      if (z <= 0) return '0;
      r = (longint'(z) + half) >> 31;
      if (r > pi_q) r = pi_q;
      return r[ANG_W-1:0];
   endfunction

   function automatic logic [DATA_W-1:0] sat_quot(longint num, int sh, longint unsigned den);
      longint unsigned mag;
      longint unsigned q;
      mag = (num < 0) ? -num : num;
      q   = (mag << sh) / den;
      if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
      return DATA_W'((num < 0) ? -longint'(q) : longint'(q));
   endfunction

   function automatic rsp_type predict_pose(req_type m);
      rsp_type         p;
      longint          e [9];
      longint          tr;
      longint          c2;
      longint          d;
      longint unsigned s2;
      longint unsigned q;
      int              col;
      e = '{m.entry_r0c0, m.entry_r0c1, m.entry_r0c2, m.entry_r1c0, m.entry_r1c1,
            m.entry_r1c2, m.entry_r2c0, m.entry_r2c1, m.entry_r2c2};
      p = '0;
      p.case_code = CODE_NORMAL;
      if (e[0] - ONE <= ident_tol && ONE - e[0] <= ident_tol &&
          e[4] - ONE <= ident_tol && ONE - e[4] <= ident_tol &&
          e[8] - ONE <= ident_tol && ONE - e[8] <= ident_tol) begin
         p.case_code = CODE_IDENT;
         return p;
      end
      tr = e[0] + e[4] + e[8];
      c2 = tr - ONE;
      if (c2 > 2 * ONE) c2 = 2 * ONE;
      if (c2 < -2 * ONE) c2 = -2 * ONE;
      s2 = int_sqrt((64'd1 << 62) - longint'(c2 * c2));
      p.angle = rot_angle(c2, s2);
      if (tr + ONE < pi_tol) begin
         // near pi: first usable column in order 2, 1, 0
         col = -1;
         if (e[8] + ONE > pi_tol) col = 2;
         else if (e[4] + ONE > pi_tol) col = 1;
         else if (e[0] + ONE > pi_tol) col = 0;
         if (col < 0) begin
            p.case_code = CODE_ERROR;
         end else begin
            d = e[col * 4] + ONE;
            q = int_sqrt(longint'(2 * d) << FRAC_BITS);
            case (col)
               2: begin
                  p.axis_x = sat_quot(e[2], FRAC_BITS, q);
                  p.axis_y = sat_quot(e[5], FRAC_BITS, q);
                  p.axis_z = sat_quot(d, FRAC_BITS, q);
                  p.case_code = CODE_PI_COL2;
               end
               1: begin
                  p.axis_x = sat_quot(e[1], FRAC_BITS, q);
                  p.axis_y = sat_quot(d, FRAC_BITS, q);
                  p.axis_z = sat_quot(e[7], FRAC_BITS, q);
                  p.case_code = CODE_PI_COL1;
               end
               default: begin
                  p.axis_x = sat_quot(d, FRAC_BITS, q);
                  p.axis_y = sat_quot(e[3], FRAC_BITS, q);
                  p.axis_z = sat_quot(e[6], FRAC_BITS, q);
                  p.case_code = CODE_PI_COL0;
               end
            endcase
         end
      end else if (s2 == 0) begin
         p.case_code = CODE_ERROR;
      end else begin
         p.axis_x = sat_quot(e[7] - e[5], FRAC_BITS + 1, s2);
         p.axis_y = sat_quot(e[2] - e[6], FRAC_BITS + 1, s2);
         p.axis_z = sat_quot(e[3] - e[1], FRAC_BITS + 1, s2);
      end
      return p;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   initial begin
      fail_count = 0;
      quarter_pi = 4 * atan_recip(5) - atan_recip(239);
      atan_q60[0] = quarter_pi;
      for (int i = 1; i < CORDIC_STEPS; i++) begin
         atan_q60[i] = 0;
         for (int k = 0; i * (2 * k + 1) <= 60; k++)
            atan_q60[i] = (k % 2 == 1)
               ? atan_q60[i] - longint'((64'd1 << (60 - i * (2 * k + 1))) / (2 * k + 1))
               : atan_q60[i] + longint'((64'd1 << (60 - i * (2 * k + 1))) / (2 * k + 1));
      end
   end

   assign pending = expected_poses.size();

   always @(posedge clock) begin
      rsp_type exp_pose;
      if (reset) begin
         ident_tol = 1;
         pi_tol    = 1;
         expected_poses.delete();
      end else begin
         if (csr_wr_en) begin
            if (csr_index == CSR_IDENT_TOL) ident_tol = longint'(csr_wdata);
            else pi_tol = longint'(csr_wdata);
         end
         if (req_valid && !req_stall)
            expected_poses.push_back(predict_pose(req_data));
         if (rsp_valid && !rsp_stall) begin
            if (expected_poses.size() == 0) begin
               $display("unexpected response transaction at %0t", $realtime);
               fail_count++;
            end else begin
               exp_pose = expected_poses.pop_front();
               if (rsp_data.axis_x !== exp_pose.axis_x)
                  report_mismatch("axis_x", rsp_data.axis_x, exp_pose.axis_x);
               if (rsp_data.axis_y !== exp_pose.axis_y)
                  report_mismatch("axis_y", rsp_data.axis_y, exp_pose.axis_y);
               if (rsp_data.axis_z !== exp_pose.axis_z)
                  report_mismatch("axis_z", rsp_data.axis_z, exp_pose.axis_z);
               if (rsp_data.angle !== exp_pose.angle)
                  report_mismatch("angle", rsp_data.angle, exp_pose.angle);
               if (rsp_data.case_code !== exp_pose.case_code)
                  report_mismatch("case_code", rsp_data.case_code, exp_pose.case_code);
            end
         end
      end
   end

endmodule

/* tb/tb.sv */
module tb;
   import rmlm_pkg::*;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_stall;
   rsp_type               rsp_data;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CFG_W-1:0]      csr_wdata;
   int                    fail_count;
   int                    pending;

   // idle percentages for the two sides, changed per phase
   int                    send_idle_pct;
   int                    recv_stall_pct;

   localparam real Q30 = 1073741824.0;
   localparam real PI  = 3.14159265358979;

   rotation_matrix_log_map_core dut (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .rsp_valid, .rsp_stall, .rsp_data, .csr_wr_en, .csr_index, .csr_wdata
   );

   rmlm_checker checker_i (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .rsp_valid, .rsp_stall, .rsp_data, .csr_wr_en, .csr_index, .csr_wdata,
      .fail_count, .pending
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Watchdog: far beyond the slowest run (about 1100 transactions, heavy stalls)
   initial begin
      #4000000;
      $display("RESULT: ERROR");
      $finish;
   end

   // Receiver back-pressure, redrawn each cycle
   always @(posedge clock) begin
      rsp_stall <= (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);
   end

   function automatic logic signed [DATA_W-1:0] to_q30(real v);
      return $rtoi(v * Q30);
   endfunction

   function automatic real unit_rand();
      return $urandom / 4294967296.0;
   endfunction

   // Rotation matrix from axis and angle (Rodrigues), quantized to Q1.30
   function automatic req_type rot_matrix(real kx, real ky, real kz, real th);
      req_type m;
      real     n;
      real     c;
      real     s;
      real     v;
      n = $sqrt(kx * kx + ky * ky + kz * kz);
      if (n < 1e-9) begin
         kx = 1.0; n = 1.0;
      end
      kx = kx / n; ky = ky / n; kz = kz / n;
      c = $cos(th); s = $sin(th); v = 1.0 - c;
      m.entry_r0c0 = to_q30(c + kx * kx * v);
      m.entry_r0c1 = to_q30(kx * ky * v - kz * s);
      m.entry_r0c2 = to_q30(kx * kz * v + ky * s);
      m.entry_r1c0 = to_q30(ky * kx * v + kz * s);
      m.entry_r1c1 = to_q30(c + ky * ky * v);
      m.entry_r1c2 = to_q30(ky * kz * v - kx * s);
      m.entry_r2c0 = to_q30(kz * kx * v - ky * s);
      m.entry_r2c1 = to_q30(kz * ky * v + kx * s);
      m.entry_r2c2 = to_q30(c + kz * kz * v);
      return m;
   endfunction

   function automatic req_type diag_matrix(int d0, int d1, int d2, int off);
      req_type m;
      m = {9{off}};
      m.entry_r0c0 = d0;
      m.entry_r1c1 = d1;
      m.entry_r2c2 = d2;
      return m;
   endfunction

   // One transaction; valid stays high into the next one unless an idle cycle intervenes
   task automatic send_matrix(req_type m);
      while ((send_idle_pct > 0) && ($urandom_range(99) < send_idle_pct)) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= m;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic write_csr(csr_index_type idx, logic [CFG_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic random_matrix();
      req_type m;
      int      pick;
      pick = $urandom_range(99);
      if (pick < 40) begin
         m = rot_matrix(unit_rand() - 0.5, unit_rand() - 0.5, unit_rand() - 0.5,
                        unit_rand() * PI);
      end else if (pick < 60) begin
         // near a half turn: exercises the column-select path
         m = rot_matrix(unit_rand() - 0.5, unit_rand() - 0.5, unit_rand() - 0.5,
                        PI - unit_rand() * unit_rand() * 0.01);
      end else if (pick < 70) begin
         // near identity: against the identity tolerance
         m = rot_matrix(unit_rand() - 0.5, unit_rand() - 0.5, unit_rand() - 0.5,
                        unit_rand() * unit_rand() * 0.001);
      end else if (pick < 80) begin
         // exact half turn about a coordinate axis, small jitter on the diagonal
         case ($urandom_range(2))
            0: m = diag_matrix(1 << 30, -(1 << 30), -(1 << 30), 0);
            1: m = diag_matrix(-(1 << 30), 1 << 30, -(1 << 30), 0);
            default: m = diag_matrix(-(1 << 30), -(1 << 30), 1 << 30, 0);
         endcase
         m.entry_r0c0 += $signed($urandom_range(64)) - 32;
         m.entry_r1c1 += $signed($urandom_range(64)) - 32;
         m.entry_r2c2 += $signed($urandom_range(64)) - 32;
      end else if (pick < 90) begin
         m = {$urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom, $urandom, $urandom, $urandom};
      end else begin
         // in-range noise
         m = '0;
         for (int i = 0; i < 9; i++)
            m[i * DATA_W +: DATA_W] = $signed($urandom_range(1 << 31)) - (1 << 30);
      end
      send_matrix(m);
   endtask

   task automatic directed_matrices();
      localparam int ONE = 1 << 30;
      send_matrix(diag_matrix(ONE, ONE, ONE, 0));
      send_matrix(diag_matrix(ONE + 1, ONE - 1, ONE, 0));
      // trace at the top but outside a small identity tolerance: zero sine
      send_matrix(diag_matrix(ONE + 5, ONE - 5, ONE, 0));
      send_matrix(diag_matrix(0, 0, 0, 0));
      send_matrix({9{32'h7FFF_FFFF}});
      send_matrix({9{32'h8000_0000}});
      send_matrix({9{32'hFFFF_FFFF}});
      send_matrix(diag_matrix(-ONE, -ONE, -ONE, 0));
      send_matrix(diag_matrix(ONE, -ONE, -ONE, 0));
      send_matrix(diag_matrix(-ONE, ONE, -ONE, 0));
      send_matrix(diag_matrix(-ONE, -ONE, ONE, 0));
      send_matrix(diag_matrix(-ONE, -ONE, ONE, ONE));
      send_matrix(rot_matrix(0.0, 0.0, 1.0, PI / 2.0));
      send_matrix(rot_matrix(1.0, 0.0, 0.0, PI / 3.0));
      send_matrix(rot_matrix(0.0, 1.0, 0.0, 2.5));
      send_matrix(rot_matrix(1.0, 1.0, 1.0, PI - 1e-6));
      send_matrix(rot_matrix(1.0, -2.0, 0.5, 1e-4));
      // tiny sine with large skew part: axis saturation
      send_matrix('{entry_r0c0: ONE - 4, entry_r0c1: -ONE, entry_r0c2: ONE,
                    entry_r1c0: ONE, entry_r1c1: ONE, entry_r1c2: -ONE,
                    entry_r2c0: -ONE, entry_r2c1: ONE, entry_r2c2: ONE});
      send_matrix(diag_matrix(ONE, ONE, ONE, 32'h7FFF_FFFF));
   endtask

   initial begin
      logic [CFG_W-1:0] id_tols [8];
      logic [CFG_W-1:0] pi_tols [8];
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data       = '0;
      rsp_stall      = 1'b0;
      csr_wr_en      = 1'b0;
      csr_index      = CSR_IDENT_TOL;
      csr_wdata      = '0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      id_tols = '{1, 0, 1 << 30, 1 << 20, 1, 1 << 30, 0, 1 << 12};
      pi_tols = '{1, 0, 1 << 30, 1 << 24, 1 << 16, 0, 1 << 30, 1 << 20};
      id_tols[7] = $urandom_range(1 << 30);
      pi_tols[7] = $urandom_range(1 << 30);
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // phase 0 runs at reset tolerances, then each phase reprograms both
      for (int ph = 0; ph < 8; ph++) begin
         if (ph > 0) begin
            write_csr(CSR_IDENT_TOL, id_tols[ph]);
            write_csr(CSR_PI_TOL, pi_tols[ph]);
         end
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
            default: begin send_idle_pct = 11; recv_stall_pct = 11; end
         endcase
         if (ph == 0 || ph == 2 || ph == 6) directed_matrices();
         for (int n = 0; n < 131; n++) random_matrix();
         drain();
      end

      if (fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

/* rotation_matrix_log_map_core.f */
rtl/rmlm_pkg.sv
rtl/rmlm_isqrt_pipe.sv
rtl/rmlm_div_pipe.sv
rtl/rotation_matrix_log_map_core.sv
tb/rmlm_checker.sv
tb/tb.sv
